>>> design/adc_iir_pkg.sv
// Shared types, constants and coefficient tables for the scaled ADC bandpass IIR.
// Used by adc_iir_seq, adc_iir_mac and adc_scale_iir_bandpass_top.
package adc_iir_pkg;

  localparam int SAMPLE_W         = 16;
  localparam int DATA_W           = 32;
  localparam int FSV_W            = 5;
  localparam logic [FSV_W-1:0] FSV_RESET = FSV_W'(10);

  localparam int ORDER_DEF        = 10;
  localparam int COEF_FRAC_DEF    = 26;
  localparam int SAMPLE_FRAC_BITS = 24;
  localparam int SCALE_SHIFT      = SAMPLE_FRAC_BITS - 15;

  localparam int TAB_FRAC         = 30;
  localparam int MAX_TAPS         = 16;
  localparam int TAP_IDX_W        = $clog2(MAX_TAPS + 1);

  // Numerator b0..b10 and negated denominator -a1..-a10, scaled by 2^30.
  localparam logic signed [63:0] NUM_TAB [MAX_TAPS+1] = '{
    64'sd7444467, 64'sd0, -64'sd37222313, 64'sd0, 64'sd74444625, 64'sd0,
    -64'sd74444625, 64'sd0, 64'sd37222313, 64'sd0, -64'sd7444467,
    64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0
  };

  localparam logic signed [63:0] FB_TAB [MAX_TAPS+1] = '{
    64'sd0, 64'sd5944349488, -64'sd15590558895, 64'sd25729110206,
    -64'sd29732995564, 64'sd25128481600, -64'sd15682304776, 64'sd7125084864,
    -64'sd2258932069, 64'sd452620350, -64'sd43711482,
    64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0
  };

  // Control word that travels with each tap from the sequencer to the MAC.
  typedef struct packed {
    logic                 vld;
    logic                 first;
    logic                 last;
    logic                 fb;
    logic [TAP_IDX_W-1:0] idx;
  } tap_ctl_t;

  // Coefficient rounded half up to frac fractional bits.
  function automatic logic signed [63:0] coef_quant(input logic fb,
                                                    input logic [TAP_IDX_W-1:0] idx,
                                                    input int frac);
    logic signed [63:0] c;
    int                 sh;
    c  = '0;
    sh = TAB_FRAC - frac;
    if (idx <= TAP_IDX_W'(MAX_TAPS)) begin
      c = fb ? FB_TAB[idx] : NUM_TAB[idx];
    end
    if (sh > 0) begin
      c = (c + (64'sd1 <<< (sh - 1))) >>> sh;
    end
    return c;
  endfunction

endpackage

>>> design/adc_iir_hist_mem.sv
// History memory: one write port, one read port, registered read data.
// Depends on adc_iir_pkg for the data width; instantiated twice by adc_iir_seq.
module adc_iir_hist_mem #(
  parameter int DEPTH  = adc_iir_pkg::ORDER_DEF,
  parameter int ADDR_W = 4
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [ADDR_W-1:0]                   waddr_i,
  input  logic signed [adc_iir_pkg::DATA_W-1:0] wdata_i,
  input  logic                                re_i,
  input  logic [ADDR_W-1:0]                   raddr_i,
  output logic signed [adc_iir_pkg::DATA_W-1:0] rdata_o
);

  logic signed [adc_iir_pkg::DATA_W-1:0] mem_q [DEPTH];
  logic signed [adc_iir_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/adc_iir_mac.sv
// Shared multiply-accumulate: registered product, exact accumulator, round and saturate.
// Depends on adc_iir_pkg for the coefficient tables and the tap control struct.
module adc_iir_mac #(
  parameter int COEF_FRAC_BITS = adc_iir_pkg::COEF_FRAC_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  adc_iir_pkg::tap_ctl_t                 ctl_i,
  input  logic signed [adc_iir_pkg::DATA_W-1:0] op_i,
  output logic signed [adc_iir_pkg::DATA_W-1:0] y_o,
  output logic                                  y_vld_o
);

  localparam int COEF_W = COEF_FRAC_BITS + 6;
  localparam int PROD_W = adc_iir_pkg::DATA_W + COEF_W;
  localparam int ACC_W  = PROD_W + 5;
  localparam int SH_W   = ACC_W - COEF_FRAC_BITS;
  localparam int DW     = adc_iir_pkg::DATA_W;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

  logic signed [63:0]       coef64;
  logic signed [COEF_W-1:0] coef;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic                     p_vld_q, p_first_q, p_last_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     done_q;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [SH_W-1:0]   shd;
  logic                     ovf;
  logic signed [DW-1:0]     y_d, y_q;
  logic                     y_vld_q;

  assign coef64 = adc_iir_pkg::coef_quant(ctl_i.fb, ctl_i.idx, COEF_FRAC_BITS);
  assign coef   = coef64[COEF_W-1:0];
  assign prod_d = PROD_W'(op_i) * PROD_W'(coef);

  // Floor after adding half an LSB, then clamp to 32 bits.
  assign rnd = acc_q + HALF;
  assign shd = rnd[ACC_W-1:COEF_FRAC_BITS];
  assign ovf = !((&shd[SH_W-1:DW-1]) || !(|shd[SH_W-1:DW-1]));

  always_comb begin
    if (ovf) begin
      y_d = shd[SH_W-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      y_d = shd[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q   <= 1'b0;
      p_first_q <= 1'b0;
      p_last_q  <= 1'b0;
      done_q    <= 1'b0;
      y_vld_q   <= 1'b0;
    end else begin
      p_vld_q   <= ctl_i.vld;
      p_first_q <= ctl_i.first;
      p_last_q  <= ctl_i.last;
      done_q    <= p_vld_q && p_last_q;
      y_vld_q   <= done_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.vld) begin
      prod_q <= prod_d;
    end
    if (p_vld_q) begin
      acc_q <= p_first_q ? ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
    end
    // Hold the result until the next item finishes.
    if (done_q) begin
      y_q <= y_d;
    end
  end

  assign y_o     = y_q;
  assign y_vld_o = y_vld_q;

endmodule

>>> design/adc_iir_seq.sv
// Tap sequencer: walks both history memories, feeds the MAC, writes back x and y.
// Depends on adc_iir_pkg and adc_iir_hist_mem.
module adc_iir_seq #(
  parameter int ORDER = adc_iir_pkg::ORDER_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [adc_iir_pkg::DATA_W-1:0] x_i,
  input  logic signed [adc_iir_pkg::DATA_W-1:0] y_i,
  input  logic                                  y_vld_i,
  input  logic                                  out_free_i,
  output logic                                  idle_o,
  output logic                                  load_o,
  output adc_iir_pkg::tap_ctl_t                 ctl_o,
  output logic signed [adc_iir_pkg::DATA_W-1:0] op_o
);

  localparam int PTR_W  = (ORDER > 1) ? $clog2(ORDER) : 1;
  localparam int TAP_W  = $clog2(2 * ORDER + 1);
  localparam int FILL_W = $clog2(ORDER + 1);
  localparam int DW     = adc_iir_pkg::DATA_W;
  localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(ORDER - 1);
  localparam logic [TAP_W-1:0]  TAP_MID  = TAP_W'(ORDER);
  localparam logic [TAP_W-1:0]  TAP_END  = TAP_W'(2 * ORDER);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(ORDER);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_HOLD} state_e;

  state_e                state_q;
  logic [TAP_W-1:0]      tap_q;
  logic [PTR_W-1:0]      rp_q, wr_ptr_q, newest;
  logic [FILL_W-1:0]     k_q, fill_q;
  logic signed [DW-1:0]  x_q;
  adc_iir_pkg::tap_ctl_t s1_ctl_q;
  logic                  s1_ok_q;
  logic                  is_fb;
  logic [TAP_W-1:0]      idx_full;
  logic                  commit;
  logic                  rd_en;
  logic signed [DW-1:0]  in_rdata, out_rdata;

  assign newest   = (wr_ptr_q == '0) ? LAST_PTR : wr_ptr_q - PTR_W'(1);
  assign is_fb    = tap_q > TAP_MID;
  assign idx_full = is_fb ? tap_q - TAP_MID : tap_q;
  assign rd_en    = (state_q == S_RUN);
  assign commit   = ((state_q == S_DRAIN) && y_vld_i && out_free_i) ||
                    ((state_q == S_HOLD) && out_free_i);

  adc_iir_hist_mem #(.DEPTH(ORDER), .ADDR_W(PTR_W)) u_in_hist (
    .clk_i   (clk_i),
    .we_i    (commit),
    .waddr_i (wr_ptr_q),
    .wdata_i (x_q),
    .re_i    (rd_en),
    .raddr_i (rp_q),
    .rdata_o (in_rdata)
  );

  adc_iir_hist_mem #(.DEPTH(ORDER), .ADDR_W(PTR_W)) u_out_hist (
    .clk_i   (clk_i),
    .we_i    (commit),
    .waddr_i (wr_ptr_q),
    .wdata_i (y_i),
    .re_i    (rd_en),
    .raddr_i (rp_q),
    .rdata_o (out_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      tap_q    <= '0;
      rp_q     <= '0;
      k_q      <= '0;
      wr_ptr_q <= '0;
      fill_q   <= '0;
      x_q      <= '0;
      s1_ctl_q <= '0;
      s1_ok_q  <= 1'b0;
    end else begin
      s1_ctl_q.vld <= (state_q == S_RUN);
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            x_q     <= x_i;
            tap_q   <= '0;
            rp_q    <= newest;
            k_q     <= '0;
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          s1_ctl_q.first <= (tap_q == '0);
          s1_ctl_q.last  <= (tap_q == TAP_END);
          s1_ctl_q.fb    <= is_fb;
          s1_ctl_q.idx   <= adc_iir_pkg::TAP_IDX_W'(idx_full);
          // Entries never written read as zero.
          s1_ok_q        <= (tap_q == '0) || (k_q < fill_q);
          if (tap_q != '0) begin
            if (tap_q == TAP_MID) begin
              rp_q <= newest;
              k_q  <= '0;
            end else begin
              rp_q <= (rp_q == '0) ? LAST_PTR : rp_q - PTR_W'(1);
              k_q  <= k_q + FILL_W'(1);
            end
          end
          tap_q <= tap_q + TAP_W'(1);
          if (tap_q == TAP_END) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (y_vld_i && !out_free_i) begin
            state_q <= S_HOLD;
          end
        end
        S_HOLD: begin
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if (commit) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
        if (fill_q != FILL_MAX) begin
          fill_q <= fill_q + FILL_W'(1);
        end
        state_q <= S_IDLE;
      end
    end
  end

  always_comb begin
    if (s1_ctl_q.first) begin
      op_o = x_q;
    end else if (!s1_ok_q) begin
      op_o = '0;
    end else if (s1_ctl_q.fb) begin
      op_o = out_rdata;
    end else begin
      op_o = in_rdata;
    end
  end

  assign ctl_o  = s1_ctl_q;
  assign idle_o = (state_q == S_IDLE);
  assign load_o = commit;

endmodule

>>> design/adc_scale_iir_bandpass_top.sv
// Scaled ADC sample into a 10th-order direct-form-I bandpass IIR, Q8.24 output.
// One word at a time: a new word is accepted only while the sequencer is idle,
// after the last result is loaded into a free output register. A single shared
// multiplier steps through the 2*ORDER+1 taps read from the history memories.
// Reset: full scale returns to 10 and both histories read as zero until refilled;
// no clearing pass, the block takes words from the first cycle after reset.
module adc_scale_iir_bandpass_top #(
  parameter int ORDER          = adc_iir_pkg::ORDER_DEF,
  parameter int COEF_FRAC_BITS = adc_iir_pkg::COEF_FRAC_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [adc_iir_pkg::FSV_W-1:0]           cfg_data_i,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [adc_iir_pkg::SAMPLE_W-1:0] adc_sample_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [adc_iir_pkg::DATA_W-1:0]   filtered_volts_o
);

  localparam int DW    = adc_iir_pkg::DATA_W;
  localparam int SCL_W = adc_iir_pkg::SAMPLE_W + adc_iir_pkg::FSV_W + 1;

  logic [adc_iir_pkg::FSV_W-1:0] fsv_q;
  logic signed [adc_iir_pkg::FSV_W:0] fsv_s;
  logic signed [adc_iir_pkg::SAMPLE_W+adc_iir_pkg::FSV_W:0] scl_prod;
  logic signed [63:0]    scl_wide;
  logic signed [DW-1:0]  x_d;
  logic                  start;
  logic                  idle;
  logic                  load;
  logic                  out_free;
  logic                  y_vld;
  logic signed [DW-1:0]  y;
  logic signed [DW-1:0]  op;
  adc_iir_pkg::tap_ctl_t ctl;
  logic                  out_valid_q;
  logic signed [DW-1:0]  fv_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsv_q <= adc_iir_pkg::FSV_RESET;
    end else if (cfg_valid_i) begin
      fsv_q <= cfg_data_i;
    end
  end

  // sample * full_scale / 32768 in Q8.24 is an exact left shift.
  assign fsv_s    = signed'({1'b0, fsv_q});
  assign scl_prod = SCL_W'(adc_sample_i) * SCL_W'(fsv_s);
  assign scl_wide = 64'(scl_prod) <<< adc_iir_pkg::SCALE_SHIFT;

  always_comb begin
    if (scl_wide > 64'sh7fff_ffff) begin
      x_d = {1'b0, {(DW-1){1'b1}}};
    end else if (scl_wide < -64'sh8000_0000) begin
      x_d = {1'b1, {(DW-1){1'b0}}};
    end else begin
      x_d = scl_wide[DW-1:0];
    end
  end

  assign in_ready_o = idle;
  assign start      = in_valid_i && idle;
  assign out_free   = !out_valid_q || out_ready_i;

  adc_iir_seq #(.ORDER(ORDER)) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .x_i        (x_d),
    .y_i        (y),
    .y_vld_i    (y_vld),
    .out_free_i (out_free),
    .idle_o     (idle),
    .load_o     (load),
    .ctl_o      (ctl),
    .op_o       (op)
  );

  adc_iir_mac #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .op_i    (op),
    .y_o     (y),
    .y_vld_o (y_vld)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      fv_q <= y;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_volts_o = fv_q;

endmodule
